FILE: sv/psfp_pkg.sv
// ---------------------------------------------------------------------------
// Particle sensor frame parser package
// Shared transaction types, parser state and status codes.
// ---------------------------------------------------------------------------
package psfp_pkg;

    localparam logic [7:0] HDR_SHORT  = 8'h40;
    localparam logic [7:0] HDR_LONG   = 8'h42;
    localparam logic [7:0] HDR_NACK   = 8'h96;
    localparam logic [7:0] HDR_ACK    = 8'hA5;
    localparam logic [7:0] SHORT_LEN1 = 8'h05;
    localparam logic [7:0] SHORT_LEN2 = 8'h04;
    localparam logic [7:0] LONG_MAGIC = 8'h4D;
    localparam logic [7:0] LONG_LEN   = 8'd28;

    localparam logic [4:0] IDX_SHORT_LAST = 5'd7;
    localparam logic [4:0] IDX_LONG_SUMHI = 5'd30;
    localparam logic [4:0] IDX_LONG_LAST  = 5'd31;

    localparam logic [2:0] ST_SHORT_OK  = 3'd0;
    localparam logic [2:0] ST_LONG_OK   = 3'd1;
    localparam logic [2:0] ST_ACK       = 3'd2;
    localparam logic [2:0] ST_NACK      = 3'd3;
    localparam logic [2:0] ST_MALFORMED = 3'd4;
    localparam logic [2:0] ST_CHECKSUM  = 3'd5;
    localparam logic [2:0] ST_UNKNOWN   = 3'd6;
    localparam logic [2:0] ST_TIMEOUT   = 3'd7;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_LONG  = 2'd1,
        KIND_NACK  = 2'd2,
        KIND_ACK   = 2'd3
    } frame_kind_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pm25;
        logic [15:0] pm10;
    } out_item_t;

    typedef struct packed {
        logic        in_frame;
        frame_kind_t frame_kind;
        logic [4:0]  byte_index;
        logic [15:0] running_sum;
        logic        layout_ok;
        logic [7:0]  sum_high_byte;
        logic [15:0] pm25_capture;
        logic [15:0] pm10_capture;
        logic [15:0] pm25_value;
        logic [15:0] pm10_value;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        in_frame:      1'b0,
        frame_kind:    KIND_SHORT,
        byte_index:    5'd0,
        running_sum:   16'd0,
        layout_ok:     1'b1,
        sum_high_byte: 8'd0,
        pm25_capture:  16'd0,
        pm10_capture:  16'd0,
        pm25_value:    16'd0,
        pm10_value:    16'd0
    };

endpackage

FILE: sv/particle_sensor_frame_parser.sv
// ---------------------------------------------------------------------------
// Particle sensor frame parser
// Byte-at-a-time parser for particle sensor UART response frames.
// ---------------------------------------------------------------------------
// Usage: each input transaction on s_data carries either a received byte
// (op = 0) or a receive timeout (op = 1). A finished frame, an unknown header
// or a timeout inside a frame yields one result transaction on m_data with a
// status code and the latest good PM2.5 and PM10 readings.
// Throughput is one input transaction per cycle while the receiver takes
// results: the input register, the single-pass step logic and the result
// register form a two-stage pipeline. A result is written to the result
// register, and shown on m_valid, when its item moves on from the input
// register. Items that produce no result still pass through the pipeline.
// When the receiver holds m_ready low, the result register keeps its
// transaction and the item in the input register waits; s_ready then stays
// high only until the input register is full.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to idle with the stored readings cleared to zero.
// ---------------------------------------------------------------------------
module particle_sensor_frame_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  psfp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output psfp_pkg::out_item_t m_data
);
    import psfp_pkg::*;

    logic         in_valid_reg;
    in_item_t     in_data_reg;
    logic         out_valid_reg;
    out_item_t    out_data_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         has_result;
    out_item_t    result;
    logic         advance;

    // The held item moves on once the result register has room for it.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    psfp_step u_step (
        .item       (in_data_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= PARSE_STATE_RESET;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            state_reg     <= state_next;
            out_valid_reg <= has_result;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            out_data_reg <= result;
        end
    end

endmodule

FILE: sv/psfp_step.sv
// ---------------------------------------------------------------------------
// Particle sensor frame parser step logic
// Computes the next parser state and the optional result for one item.
// ---------------------------------------------------------------------------
module psfp_step (
    input  psfp_pkg::in_item_t     item,
    input  psfp_pkg::parse_state_t cur,
    output psfp_pkg::parse_state_t nxt,
    output logic                   has_result,
    output psfp_pkg::out_item_t    result
);
    import psfp_pkg::*;

    logic [7:0]  b;
    logic [4:0]  idx;
    logic [7:0]  short_cs;
    logic [15:0] long_got;
    logic [15:0] sum_plus;
    logic [2:0]  status;

    assign b        = item.rx_byte;
    assign idx      = cur.byte_index;
    assign short_cs = 8'd0 - cur.running_sum[7:0];
    assign long_got = {cur.sum_high_byte, b};
    assign sum_plus = cur.running_sum + {8'd0, b};

    always_comb begin
        nxt        = cur;
        has_result = 1'b0;
        status     = ST_TIMEOUT;

        if (item.op == OP_TIMEOUT) begin
            if (cur.in_frame) begin
                nxt.in_frame = 1'b0;
                has_result   = 1'b1;
                status       = ST_TIMEOUT;
            end
        end else if (!cur.in_frame) begin
            // Idle: zero bytes are line noise, anything else must be a header.
            if (b != 8'd0) begin
                nxt.in_frame    = 1'b1;
                nxt.byte_index  = 5'd1;
                nxt.running_sum = {8'd0, b};
                nxt.layout_ok   = 1'b1;
                unique case (b)
                    HDR_SHORT: nxt.frame_kind = KIND_SHORT;
                    HDR_LONG:  nxt.frame_kind = KIND_LONG;
                    HDR_NACK:  nxt.frame_kind = KIND_NACK;
                    HDR_ACK:   nxt.frame_kind = KIND_ACK;
                    default: begin
                        nxt.in_frame    = 1'b0;
                        nxt.byte_index  = cur.byte_index;
                        nxt.running_sum = cur.running_sum;
                        nxt.layout_ok   = cur.layout_ok;
                        has_result      = 1'b1;
                        status          = ST_UNKNOWN;
                    end
                endcase
            end
        end else begin
            unique case (cur.frame_kind)
                KIND_NACK, KIND_ACK: begin
                    nxt.in_frame = 1'b0;
                    has_result   = 1'b1;
                    if (cur.frame_kind == KIND_NACK) begin
                        status = (b == HDR_NACK) ? ST_NACK : ST_MALFORMED;
                    end else begin
                        status = (b == HDR_ACK) ? ST_ACK : ST_MALFORMED;
                    end
                end
                KIND_SHORT: begin
                    if (idx == IDX_SHORT_LAST) begin
                        nxt.in_frame = 1'b0;
                        has_result   = 1'b1;
                        if (!cur.layout_ok) begin
                            status = ST_MALFORMED;
                        end else if (b != short_cs) begin
                            status = ST_CHECKSUM;
                        end else begin
                            status         = ST_SHORT_OK;
                            nxt.pm25_value = cur.pm25_capture;
                            nxt.pm10_value = cur.pm10_capture;
                        end
                    end else begin
                        if (idx == 5'd1 && b != SHORT_LEN1) nxt.layout_ok = 1'b0;
                        if (idx == 5'd2 && b != SHORT_LEN2) nxt.layout_ok = 1'b0;
                        if (idx == 5'd3) nxt.pm25_capture[15:8] = b;
                        if (idx == 5'd4) nxt.pm25_capture[7:0]  = b;
                        if (idx == 5'd5) nxt.pm10_capture[15:8] = b;
                        if (idx == 5'd6) nxt.pm10_capture[7:0]  = b;
                        nxt.running_sum = sum_plus;
                        nxt.byte_index  = idx + 5'd1;
                    end
                end
                KIND_LONG: begin
                    if (idx == IDX_LONG_LAST) begin
                        nxt.in_frame = 1'b0;
                        has_result   = 1'b1;
                        if (!cur.layout_ok) begin
                            status = ST_MALFORMED;
                        end else if (long_got != cur.running_sum) begin
                            status = ST_CHECKSUM;
                        end else begin
                            status         = ST_LONG_OK;
                            nxt.pm25_value = cur.pm25_capture;
                            nxt.pm10_value = cur.pm10_capture;
                        end
                    end else begin
                        // The high checksum byte is held back, not summed.
                        if (idx == IDX_LONG_SUMHI) begin
                            nxt.sum_high_byte = b;
                        end else begin
                            if (idx == 5'd1 && b != LONG_MAGIC) nxt.layout_ok = 1'b0;
                            if (idx == 5'd2 && b != 8'd0)       nxt.layout_ok = 1'b0;
                            if (idx == 5'd3 && b != LONG_LEN)   nxt.layout_ok = 1'b0;
                            if (idx == 5'd6) nxt.pm25_capture[15:8] = b;
                            if (idx == 5'd7) nxt.pm25_capture[7:0]  = b;
                            if (idx == 5'd8) nxt.pm10_capture[15:8] = b;
                            if (idx == 5'd9) nxt.pm10_capture[7:0]  = b;
                            nxt.running_sum = sum_plus;
                        end
                        nxt.byte_index = idx + 5'd1;
                    end
                end
                default: ;
            endcase
        end

        result.status = status;
        result.pm25   = nxt.pm25_value;
        result.pm10   = nxt.pm10_value;
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Particle sensor frame parser testbench
// Feeds byte and timeout transactions into the parser. A directed opening
// covers short, ACK and NACK headers, unknown headers, idle skips and a
// timeout inside a frame. Random well-formed frames follow, some of them
// corrupted, truncated or mixed with noise. Every result is checked against
// an in-bench model of the parser while both sides idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
    import psfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_ITEMS     = 120;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int BACKLOG_CYCLES = 240;

    typedef enum int {
        FLAW_NONE,
        FLAW_SHAPE,
        FLAW_SUM,
        FLAW_BOTH
    } flaw_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    particle_sensor_frame_parser u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    in_item_t  pending_items[$];
    out_item_t expected_reports[$];
    out_item_t predicted_report;
    out_item_t oldest_report;

    int mismatch_count  = 0;
    int items_accepted  = 0;
    int reports_checked = 0;
    int status_seen[8]  = '{default: 0};
    int send_gap        = 0;
    int stall_left      = 0;
    bit backlog_done    = 1'b0;
    int idle_cycles     = 0;

    // Parser model state, held at its reset values until the first byte.
    logic        frame_open = 1'b0;
    frame_kind_t kind       = KIND_SHORT;
    logic [4:0]  pos        = '0;
    logic [15:0] sum16      = '0;
    logic        shape_ok   = 1'b1;
    logic [7:0]  sum_hi     = '0;
    logic [15:0] pm25_new   = '0;
    logic [15:0] pm10_new   = '0;
    logic [15:0] pm25_held  = '0;
    logic [15:0] pm10_held  = '0;

    // Advances the parser model by one transaction; returns 1 when it reports.
    function automatic bit parse_item(input in_item_t item, output out_item_t report);
        logic [7:0] b;
        logic [2:0] code;
        bit         produced;
        b        = item.rx_byte;
        code     = ST_TIMEOUT;
        produced = 1'b0;
        if (item.op == OP_TIMEOUT) begin
            if (frame_open) begin
                frame_open = 1'b0;
                produced   = 1'b1;
            end
        end else if (!frame_open) begin
            if (b != 8'h00) begin
                case (b)
                    HDR_SHORT: kind = KIND_SHORT;
                    HDR_LONG:  kind = KIND_LONG;
                    HDR_NACK:  kind = KIND_NACK;
                    HDR_ACK:   kind = KIND_ACK;
                    default: begin
                        produced = 1'b1;
                        code     = ST_UNKNOWN;
                    end
                endcase
                if (!produced) begin
                    frame_open = 1'b1;
                    pos        = 5'd1;
                    sum16      = {8'h00, b};
                    shape_ok   = 1'b1;
                end
            end
        end else if (kind == KIND_NACK || kind == KIND_ACK) begin
            frame_open = 1'b0;
            produced   = 1'b1;
            if (kind == KIND_NACK)
                code = (b == HDR_NACK) ? ST_NACK : ST_MALFORMED;
            else
                code = (b == HDR_ACK) ? ST_ACK : ST_MALFORMED;
        end else if (kind == KIND_SHORT) begin
            if (pos == IDX_SHORT_LAST) begin
                frame_open = 1'b0;
                produced   = 1'b1;
                if (!shape_ok) begin
                    code = ST_MALFORMED;
                end else if (b != 8'(8'h00 - sum16[7:0])) begin
                    code = ST_CHECKSUM;
                end else begin
                    code      = ST_SHORT_OK;
                    pm25_held = pm25_new;
                    pm10_held = pm10_new;
                end
            end else begin
                case (pos)
                    5'd1: if (b != SHORT_LEN1) shape_ok = 1'b0;
                    5'd2: if (b != SHORT_LEN2) shape_ok = 1'b0;
                    5'd3: pm25_new[15:8] = b;
                    5'd4: pm25_new[7:0]  = b;
                    5'd5: pm10_new[15:8] = b;
                    5'd6: pm10_new[7:0]  = b;
                    default: ;
                endcase
                sum16 = sum16 + 16'(b);
                pos   = pos + 5'd1;
            end
        end else begin
            if (pos == IDX_LONG_LAST) begin
                frame_open = 1'b0;
                produced   = 1'b1;
                if (!shape_ok) begin
                    code = ST_MALFORMED;
                end else if ({sum_hi, b} != sum16) begin
                    code = ST_CHECKSUM;
                end else begin
                    code      = ST_LONG_OK;
                    pm25_held = pm25_new;
                    pm10_held = pm10_new;
                end
            end else if (pos == IDX_LONG_SUMHI) begin
                sum_hi = b;
                pos    = pos + 5'd1;
            end else begin
                case (pos)
                    5'd1: if (b != LONG_MAGIC) shape_ok = 1'b0;
                    5'd2: if (b != 8'h00) shape_ok = 1'b0;
                    5'd3: if (b != LONG_LEN) shape_ok = 1'b0;
                    5'd6: pm25_new[15:8] = b;
                    5'd7: pm25_new[7:0]  = b;
                    5'd8: pm10_new[15:8] = b;
                    5'd9: pm10_new[7:0]  = b;
                    default: ;
                endcase
                sum16 = sum16 + 16'(b);
                pos   = pos + 5'd1;
            end
        end
        report = '{status: code, pm25: pm25_held, pm10: pm10_held};
        return produced;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic add_byte(input logic [7:0] b);
        pending_items.push_back('{op: OP_BYTE, rx_byte: b});
    endtask

    // The byte field of a timeout is ignored, so it is left random.
    task automatic add_timeout();
        pending_items.push_back('{op: OP_TIMEOUT, rx_byte: 8'($urandom_range(0, 255))});
    endtask

    // Queues one measurement frame with random readings, optionally damaged
    // and optionally cut short by a receive timeout after cut_at bytes.
    task automatic add_measurement(input bit long_form, input flaw_t flaw, input int cut_at);
        logic [7:0]  frame [32];
        logic [15:0] total;
        int          len;
        int          pick;
        int          count;
        len   = long_form ? 32 : 8;
        total = '0;
        foreach (frame[k]) frame[k] = 8'($urandom_range(0, 255));
        if (long_form) begin
            frame[0] = HDR_LONG;
            frame[1] = LONG_MAGIC;
            frame[2] = 8'h00;
            frame[3] = LONG_LEN;
        end else begin
            frame[0] = HDR_SHORT;
            frame[1] = SHORT_LEN1;
            frame[2] = SHORT_LEN2;
        end
        if (flaw == FLAW_SHAPE || flaw == FLAW_BOTH) begin
            pick        = $urandom_range(1, long_form ? 3 : 2);
            frame[pick] = frame[pick] ^ 8'($urandom_range(1, 255));
        end
        for (int k = 0; k < len - (long_form ? 2 : 1); k++) total = total + 16'(frame[k]);
        if (long_form) begin
            frame[30] = total[15:8];
            frame[31] = total[7:0];
        end else begin
            frame[7] = 8'h00 - total[7:0];
        end
        if (flaw == FLAW_SUM || flaw == FLAW_BOTH) begin
            pick        = long_form ? $urandom_range(30, 31) : 7;
            frame[pick] = frame[pick] ^ 8'($urandom_range(1, 255));
        end
        count = (cut_at > 0) ? cut_at : len;
        for (int k = 0; k < count; k++) add_byte(frame[k]);
        if (cut_at > 0) add_timeout();
    endtask

    initial begin
        logic [7:0] extreme_short [8];
        int    choice;
        bit    long_form;
        flaw_t flaw;
        int    cut_at;
        logic [7:0] hdr;

        // Readings at their extremes: PM2.5 all ones, PM10 all zeros.
        extreme_short = '{8'h40, 8'h05, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hB9};

        // Directed opening: idle skips, unknown headers, replies, a good
        // frame, and a timeout that abandons a partial frame.
        add_byte(8'h00);
        add_timeout();
        add_byte(8'hFF);
        add_byte(8'h01);
        add_byte(HDR_ACK);
        add_byte(HDR_ACK);
        add_byte(HDR_NACK);
        add_byte(HDR_NACK);
        add_byte(HDR_ACK);
        add_byte(HDR_NACK);
        add_byte(HDR_NACK);
        add_byte(8'h00);
        foreach (extreme_short[k]) add_byte(extreme_short[k]);
        add_byte(HDR_SHORT);
        add_byte(SHORT_LEN1);
        add_timeout();

        while (pending_items.size() < RANDOM_ITEMS) begin
            choice = $urandom_range(0, 99);
            if (choice < 60) begin
                long_form = (choice >= 38);
                case ($urandom_range(0, 9))
                    0:       flaw = FLAW_SHAPE;
                    1:       flaw = FLAW_SUM;
                    2:       flaw = FLAW_BOTH;
                    default: flaw = FLAW_NONE;
                endcase
                cut_at = 0;
                if ($urandom_range(0, 9) == 0)
                    cut_at = $urandom_range(1, long_form ? 31 : 7);
                add_measurement(long_form, flaw, cut_at);
            end else if (choice < 78) begin
                hdr = $urandom_range(0, 1) ? HDR_ACK : HDR_NACK;
                add_byte(hdr);
                if ($urandom_range(0, 3) == 0)
                    add_byte(8'($urandom_range(0, 255)));
                else
                    add_byte(hdr);
            end else if (choice < 86) begin
                repeat ($urandom_range(1, 3)) add_byte(8'h00);
            end else if (choice < 94) begin
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_timeout();
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid || expected_reports.size() != 0)
            @(negedge aclk);
        // Items without a result may still be in the two-stage pipeline.
        repeat (10) @(posedge aclk);

        $display("Run covered %0d input transactions and %0d checked results.",
                 items_accepted, reports_checked);
        $display("Results by status: short %0d, long %0d, ack %0d, nack %0d, malformed %0d,",
                 status_seen[ST_SHORT_OK], status_seen[ST_LONG_OK], status_seen[ST_ACK],
                 status_seen[ST_NACK], status_seen[ST_MALFORMED]);
        $display("  checksum %0d, unknown %0d, timeout %0d; mismatches %0d.",
                 status_seen[ST_CHECKSUM], status_seen[ST_UNKNOWN],
                 status_seen[ST_TIMEOUT], mismatch_count);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Input driver: offers queued items with random gaps, none near the end.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                items_accepted++;
                if (parse_item(s_data, predicted_report))
                    expected_reports.push_back(predicted_report);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_items.pop_front();
                    if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 17);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction and stalls the output at random.
    // Once, a long hold-off lets the parser fill up and stall its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got status %0d pm25 %h pm10 %h",
                             $time, m_data.status, m_data.pm25, m_data.pm10);
                    mismatch_count++;
                end else begin
                    oldest_report = expected_reports.pop_front();
                    check_field("status", 16'(oldest_report.status), 16'(m_data.status));
                    check_field("pm25", oldest_report.pm25, m_data.pm25);
                    check_field("pm10", oldest_report.pm10, m_data.pm10);
                    status_seen[m_data.status]++;
                    reports_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!backlog_done && reports_checked >= 150) begin
                backlog_done = 1'b1;
                stall_left   = BACKLOG_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, run abandoned", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

endmodule

FILE: filelist.f
sv/psfp_pkg.sv
sv/psfp_step.sv
sv/particle_sensor_frame_parser.sv
dv/testbench.sv
